// ===== rtl/lossless_jpeg_predictive_codec_core_macros.svh =====
// Assertion macros used by the top level of the predictive codec RTL.
`ifndef LOSSLESS_JPEG_PREDICTIVE_CODEC_CORE_MACROS_SVH
`define LOSSLESS_JPEG_PREDICTIVE_CODEC_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define LJPC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Trigger in one cycle implies a consequence in the next.
`define LJPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define LJPC_ASSERT(lbl, clk, rstn, prop, msg)
`define LJPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/ljpc_pkg.sv =====
// Shared types and constants of the lossless predictive codec.
package ljpc_pkg;

  localparam int SAMPLE_W    = 10;
  localparam int PIXEL_W     = 8;
  localparam int PRED_W      = 11;
  localparam int MODE_W      = 3;
  localparam int SHIFT_W     = 3;
  localparam int WIDTH_W     = 13;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd4096;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [PIXEL_W-1:0]         pixel_t;
  typedef logic signed [PRED_W-1:0]   pred_t;
  typedef logic [SHIFT_W-1:0]         shift_t;
  typedef logic [WIDTH_W-1:0]         width_t;

  typedef enum logic [MODE_W-1:0] {
    PRED_MED        = 3'd0,
    PRED_LEFT       = 3'd1,
    PRED_ABOVE      = 3'd2,
    PRED_DIAG       = 3'd3,
    PRED_PLANE      = 3'd4,
    PRED_LEFT_GRAD  = 3'd5,
    PRED_ABOVE_GRAD = 3'd6,
    PRED_AVG        = 3'd7
  } pred_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRED_MODE   = 2'd0,
    CFG_QUANT_SHIFT = 2'd1,
    CFG_IMAGE_WIDTH = 2'd2,
    CFG_DIRECTION   = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_e;

  // Position flags of one pixel, decided in the front end.
  typedef struct packed {
    logic first_row;
    logic col_zero;
    logic last;
  } item_flags_t;

endpackage

// ===== rtl/lossless_jpeg_predictive_codec_core.sv =====
// Top level of the lossless predictive codec: config registers, front, queue, back.
// One pixel (or residual) per transaction, raster order, one result per input; the
// core sustains one transaction per clock while the output is not stalled, and each
// result passes through queue entry, execute stage and output register. The pace is set
// by the left-neighbor loop through predictor and adder in the execute stage and by the
// single read port of the row store, read as each pixel enters execute. Configuration
// is written through cfg_we_i/cfg_idx_i/cfg_data_i while the core is idle; users must
// ensure this, the core does not. The row store needs no clearing after reset.
`include "lossless_jpeg_predictive_codec_core_macros.svh"
module lossless_jpeg_predictive_codec_core #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  ljpc_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [ljpc_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [15:0]                s_axis_tdata,  // [9:0] sample
  input  logic                       s_axis_tuser,  // [0] start_of_image
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [23:0]                m_axis_tdata,  // [9:0] residual, [17:10] recon_pixel
  output logic                       m_axis_tlast
);
  import ljpc_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int QDW = SAMPLE_W + CW + $bits(item_flags_t);

  pred_mode_e  mode_q;
  shift_t      shift_q;
  width_t      width_q;
  dir_e        dir_q;

  logic          f_push;
  sample_t       f_sample;
  logic [CW-1:0] f_col;
  item_flags_t   f_flags;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic [QDW-1:0] q_head;
  sample_t       b_residual;
  pixel_t        b_recon;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= PRED_MED;
      shift_q <= '0;
      width_q <= WIDTH_RESET;
      dir_q   <= DIR_ENCODE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PRED_MODE:   mode_q  <= pred_mode_e'(cfg_data_i[MODE_W-1:0]);
        CFG_QUANT_SHIFT: shift_q <= cfg_data_i[SHIFT_W-1:0];
        CFG_IMAGE_WIDTH: width_q <= cfg_data_i[WIDTH_W-1:0];
        CFG_DIRECTION:   dir_q   <= dir_e'(cfg_data_i[0]);
        default:         mode_q  <= mode_q;
      endcase
    end
  end

  ljpc_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .width_i    (width_q),
    .s_valid_i  (s_axis_tvalid),
    .s_sample_i (s_axis_tdata[SAMPLE_W-1:0]),
    .s_sof_i    (s_axis_tuser),
    .s_ready_o  (s_axis_tready),
    .q_full_i   (q_full),
    .push_o     (f_push),
    .sample_o   (f_sample),
    .col_o      (f_col),
    .flags_o    (f_flags)
  );

  ljpc_queue #(
    .DW    (QDW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_push),
    .push_data_i ({f_sample, f_col, f_flags}),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  ljpc_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .shift_i      (shift_q),
    .dir_i        (dir_q),
    .q_valid_i    (q_valid),
    .q_sample_i   (q_head[QDW-1 -: SAMPLE_W]),
    .q_col_i      (q_head[$bits(item_flags_t) +: CW]),
    .q_flags_i    (q_head[$bits(item_flags_t)-1:0]),
    .q_pop_o      (q_pop),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_residual_o (b_residual),
    .m_recon_o    (b_recon),
    .m_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, b_recon, b_residual};

  // Check queue handshakes between front and back
  `LJPC_ASSERT(a_push_not_full, clk_i, rst_ni, !f_push || !q_full, "push into full queue")
  `LJPC_ASSERT(a_pop_not_empty, clk_i, rst_ni, !q_pop || q_valid, "pop from empty queue")
  `LJPC_ASSERT_NEXT(a_push_lands, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, q_valid, "accepted pixel missing from queue")

endmodule

// ===== rtl/ljpc_front.sv =====
// Front end: accepts pixels, tracks row and column, classifies the position.
module ljpc_front #(
  parameter int MAX_WIDTH = 4096,
  parameter int CW        = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ljpc_pkg::width_t      width_i,
  input  logic                  s_valid_i,
  input  ljpc_pkg::sample_t     s_sample_i,
  input  logic                  s_sof_i,
  output logic                  s_ready_o,
  input  logic                  q_full_i,
  output logic                  push_o,
  output ljpc_pkg::sample_t     sample_o,
  output logic [CW-1:0]         col_o,
  output ljpc_pkg::item_flags_t flags_o
);
  import ljpc_pkg::*;

  localparam int LW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;
  localparam logic [LW-1:0] MAX_W_L = LW'(MAX_WIDTH);

  logic [CW-1:0] count_q, count_d;
  logic          first_row_q, first_row_d;
  logic [LW-1:0] width_ext;
  logic [LW-1:0] wlast_ext;
  logic [CW-1:0] wlast;
  logic [CW-1:0] cnt;
  logic          fr;
  logic          last;

  // Clamp the configured width to 1..MAX_WIDTH and take its last column
  assign width_ext = LW'(width_i);
  always_comb begin
    if (width_ext == '0) begin
      wlast_ext = '0;
    end else if (width_ext > MAX_W_L) begin
      wlast_ext = MAX_W_L - LW'(1);
    end else begin
      wlast_ext = width_ext - LW'(1);
    end
  end
  assign wlast = wlast_ext[CW-1:0];

  // Classify the incoming pixel
  assign s_ready_o = !q_full_i;
  assign push_o    = s_valid_i && !q_full_i;
  assign cnt       = s_sof_i ? '0 : count_q;
  assign fr        = s_sof_i ? 1'b1 : first_row_q;
  assign last      = (cnt >= wlast);

  assign sample_o           = s_sample_i;
  assign col_o              = (cnt > wlast) ? wlast : cnt;
  assign flags_o.first_row  = fr;
  assign flags_o.col_zero   = (col_o == '0);
  assign flags_o.last       = last;

  // Advance the raster position on each accepted transaction
  always_comb begin
    count_d     = count_q;
    first_row_d = first_row_q;
    if (push_o) begin
      if (last) begin
        count_d     = '0;
        first_row_d = 1'b0;
      end else begin
        count_d     = cnt + CW'(1);
        first_row_d = fr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      first_row_q <= 1'b1;
    end else begin
      count_q     <= count_d;
      first_row_q <= first_row_d;
    end
  end

endmodule

// ===== rtl/ljpc_queue.sv =====
// Small register queue between the front end and the back end.
module ljpc_queue #(
  parameter int DW    = 26,
  parameter int DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output logic [DW-1:0] head_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [NW-1:0] count_q;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == NW'(DEPTH));
  assign head_o  = mem_q[rptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + NW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - NW'(1);
      end
    end
  end

endmodule

// ===== rtl/ljpc_back.sv =====
// Back end: row store read, prediction, residual, reconstruction, output register.
module ljpc_back #(
  parameter int MAX_WIDTH = 4096,
  parameter int CW        = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ljpc_pkg::pred_mode_e   mode_i,
  input  ljpc_pkg::shift_t       shift_i,
  input  ljpc_pkg::dir_e         dir_i,
  input  logic                   q_valid_i,
  input  ljpc_pkg::sample_t      q_sample_i,
  input  logic [CW-1:0]          q_col_i,
  input  ljpc_pkg::item_flags_t  q_flags_i,
  output logic                   q_pop_o,
  output logic                   m_valid_o,
  input  logic                   m_ready_i,
  output ljpc_pkg::sample_t      m_residual_o,
  output ljpc_pkg::pixel_t       m_recon_o,
  output logic                   m_last_o
);
  import ljpc_pkg::*;

  // Truncating halving of a signed value
  function automatic pred_t half_trunc(input pred_t v);
    pred_t s;
    s = v + $signed({{(PRED_W-1){1'b0}}, v[PRED_W-1]});
    return s >>> 1;
  endfunction

  function automatic pred_t predict(input pred_mode_e m, input pred_t a, input pred_t b,
                                    input pred_t c);
    pred_t mx, mn, res;
    mx = (a > b) ? a : b;
    mn = (a > b) ? b : a;
    unique case (m)
      PRED_MED: begin
        if (c >= mx) begin
          res = mn;
        end else if (c <= mn) begin
          res = mx;
        end else begin
          res = a + b - c;
        end
      end
      PRED_LEFT:       res = a;
      PRED_ABOVE:      res = b;
      PRED_DIAG:       res = c;
      PRED_PLANE:      res = a + b - c;
      PRED_LEFT_GRAD:  res = a + half_trunc(b - c);
      PRED_ABOVE_GRAD: res = b + half_trunc(a - c);
      PRED_AVG:        res = half_trunc(a + b);
      default:         res = a;
    endcase
    return res;
  endfunction

  pixel_t        row_mem [MAX_WIDTH];
  pixel_t        rd_q;
  logic          e_valid_q;
  sample_t       e_sample_q;
  logic [CW-1:0] e_col_q;
  item_flags_t   e_flags_q;
  logic          e_fwd_q;
  pixel_t        e_fwd_pix_q;
  pixel_t        left_q, above_left_q;
  logic          m_valid_q;
  sample_t       m_residual_q;
  pixel_t        m_recon_q;
  logic          m_last_q;

  logic          e_adv;
  pixel_t        above;
  pixel_t        b_pix;
  pred_t         pa, pb, pc, px;
  pred_t         x, diff, mask, rsd;
  pixel_t        recon;

  // Handshake between queue, execute stage and output register
  assign e_adv   = e_valid_q && (!m_valid_q || m_ready_i);
  assign q_pop_o = q_valid_i && (!e_valid_q || e_adv);

  // Neighbors; forward the pixel written in the same cycle as the read
  assign above = e_fwd_q ? e_fwd_pix_q : rd_q;
  assign b_pix = e_flags_q.first_row ? '0 : above;
  assign pa    = e_flags_q.col_zero ? '0 : pred_t'(left_q);
  assign pb    = pred_t'(b_pix);
  assign pc    = (e_flags_q.col_zero || e_flags_q.first_row) ? '0 : pred_t'(above_left_q);
  assign px    = predict(mode_i, pa, pb, pc);

  // Residual: floored error in encode, echoed input in decode
  assign x    = pred_t'(e_sample_q[PIXEL_W-1:0]);
  assign diff = x - px;
  assign mask = $signed({PRED_W{1'b1}} << shift_i);
  always_comb begin
    if (dir_i == DIR_ENCODE) begin
      rsd = diff & mask;
    end else begin
      rsd = PRED_W'(e_sample_q);
    end
  end
  assign recon = rsd[PIXEL_W-1:0] + px[PIXEL_W-1:0];

  // Row store: write on advance, read for the item entering execute
  always_ff @(posedge clk_i) begin
    if (e_adv) begin
      row_mem[e_col_q] <= recon;
    end
    if (q_pop_o) begin
      rd_q <= row_mem[q_col_i];
    end
  end

  // Execute stage payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      e_sample_q  <= q_sample_i;
      e_col_q     <= q_col_i;
      e_flags_q   <= q_flags_i;
      e_fwd_q     <= e_adv && (q_col_i == e_col_q);
      e_fwd_pix_q <= recon;
    end
    if (e_adv) begin
      m_residual_q <= rsd[SAMPLE_W-1:0];
      m_recon_q    <= recon;
      m_last_q     <= e_flags_q.last;
    end
  end

  // Control state and neighbor registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q    <= 1'b0;
      m_valid_q    <= 1'b0;
      left_q       <= '0;
      above_left_q <= '0;
    end else begin
      if (q_pop_o) begin
        e_valid_q <= 1'b1;
      end else if (e_adv) begin
        e_valid_q <= 1'b0;
      end
      if (e_adv) begin
        m_valid_q    <= 1'b1;
        left_q       <= recon;
        above_left_q <= b_pix;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_valid_o    = m_valid_q;
  assign m_residual_o = m_residual_q;
  assign m_recon_o    = m_recon_q;
  assign m_last_o     = m_last_q;

endmodule

// ===== sim/lossless_jpeg_predictive_codec_core_test.sv =====
// Self-checking testbench for the lossless predictive codec core (stream in, stream out).
module lossless_jpeg_predictive_codec_core_test;
  import ljpc_pkg::*;

  localparam int MAX_W       = 4096;
  localparam int RESET_CYC   = 12;
  localparam int DRAIN_CYC   = 8;
  localparam int HOLD_CYC    = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 950;

  // Predicts one result per pixel transaction and compares the block against it.
  class codec_scoreboard;
    typedef struct {
      logic [SAMPLE_W-1:0] residual;
      pixel_t              recon;
      logic                last;
    } pixel_result_t;

    pixel_result_t expected_px[$];
    pred_mode_e    mode;
    shift_t        shift;
    width_t        width;
    dir_e          dir;
    pixel_t        row_mem[MAX_W];
    pixel_t        left_px;
    pixel_t        diag_px;
    int unsigned   col_cnt;
    bit            first_row;
    int            errors;
    int            n_noted;
    int            n_checked;

    function new();
      mode      = PRED_MED;
      shift     = '0;
      width     = WIDTH_RESET;
      dir       = DIR_ENCODE;
      left_px   = '0;
      diag_px   = '0;
      col_cnt   = 0;
      first_row = 1'b1;
      errors    = 0;
      n_noted   = 0;
      n_checked = 0;
    endfunction

    function void set_config(pred_mode_e m, shift_t s, width_t w, dir_e d);
      mode  = m;
      shift = s;
      width = w;
      dir   = d;
    endfunction

    // Divisions truncate toward zero, as int division does.
    function int predict(int a, int b, int c);
      int hi;
      int lo;
      hi = (a > b) ? a : b;
      lo = (a < b) ? a : b;
      case (mode)
        PRED_MED: begin
          if (c >= hi) return lo;
          if (c <= lo) return hi;
          return a + b - c;
        end
        PRED_LEFT:       return a;
        PRED_ABOVE:      return b;
        PRED_DIAG:       return c;
        PRED_PLANE:      return a + b - c;
        PRED_LEFT_GRAD:  return a + (b - c) / 2;
        PRED_ABOVE_GRAD: return b + (a - c) / 2;
        default:         return (a + b) / 2;
      endcase
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] raw, logic soi);
      int            w;
      int unsigned   col;
      int            a;
      int            b;
      int            c;
      int            p;
      int            rsd;
      sample_t       sv;
      pixel_t        rec;
      pixel_result_t res;
      w = width;
      if (w < 1) w = 1;
      if (w > MAX_W) w = MAX_W;
      if (soi) begin
        col_cnt   = 0;
        first_row = 1'b1;
      end
      col = col_cnt;
      if (col >= w) col = w - 1;
      a = (col == 0) ? 0 : int'(left_px);
      b = first_row ? 0 : int'(row_mem[col]);
      c = (col == 0 || first_row) ? 0 : int'(diag_px);
      p = predict(a, b, c);
      // Encode floors the error to a multiple of 2^shift; decode echoes the input.
      if (dir == DIR_ENCODE) begin
        rsd = ((int'(raw[7:0]) - p) >>> shift) <<< shift;
      end else begin
        sv  = raw;
        rsd = sv;
      end
      rec          = pixel_t'(rsd + p);
      diag_px      = pixel_t'(b);
      left_px      = rec;
      row_mem[col] = rec;
      res.residual = rsd[SAMPLE_W-1:0];
      res.recon    = rec;
      res.last     = (col_cnt + 1 >= w);
      if (res.last) begin
        col_cnt   = 0;
        first_row = 1'b0;
      end else begin
        col_cnt = col_cnt + 1;
      end
      expected_px = {expected_px, res};
      n_noted++;
    endfunction

    function void check_output(logic [SAMPLE_W-1:0] rsd, pixel_t px, logic last);
      pixel_result_t exp_px;
      n_checked++;
      if (expected_px.size() == 0) begin
        $display("%0t: result with nothing pending, actual residual %0d recon %0d last %0b",
                 $time, signed'(rsd), px, last);
        errors++;
        return;
      end
      exp_px = expected_px.pop_front();
      if (rsd !== exp_px.residual) begin
        $display("%0t: residual mismatch, expected %0d actual %0d",
                 $time, signed'(exp_px.residual), signed'(rsd));
        errors++;
      end
      if (px !== exp_px.recon) begin
        $display("%0t: recon_pixel mismatch, expected %0d actual %0d",
                 $time, exp_px.recon, px);
        errors++;
      end
      if (last !== exp_px.last) begin
        $display("%0t: end_of_row mismatch, expected %0b actual %0b",
                 $time, exp_px.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_px.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  cfg_idx_e            cfg_idx_i;
  logic [CFG_W-1:0]    cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata;   // [9:0] sample
  logic                s_axis_tuser;   // [0] start_of_image
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [23:0]         m_axis_tdata;   // [9:0] residual, [17:10] recon_pixel
  logic                m_axis_tlast;   // end_of_row

  codec_scoreboard sb;
  int  tx_max_wait = 12;
  int  rx_max_wait = 12;
  bit  streaming   = 1'b0;
  bit  hold_req    = 1'b0;
  bit  held        = 1'b0;
  int  smooth_px   = 128;
  int  stall_cnt   = 0;

  lossless_jpeg_predictive_codec_core #(
    .MAX_WIDTH(MAX_W)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // Clock generation
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort if no transaction moves on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cnt = 0;
      end else begin
        stall_cnt = stall_cnt + 1;
      end
      if (stall_cnt >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Accept results with random back-pressure and one long hold-off
  initial begin
    int gap;
    wait (rst_ni === 1'b1);
    forever begin
      gap = $urandom_range(rx_max_wait, 0);
      if (!held && hold_req && streaming) begin
        gap  = HOLD_CYC;
        held = 1'b1;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_output(m_axis_tdata[9:0], m_axis_tdata[17:10], m_axis_tlast);
    end
  end

  function automatic int eff_width(width_t w);
    if (w == 0) return 1;
    if (w > MAX_W) return MAX_W;
    return w;
  endfunction

  // Pixels mix extremes, smooth runs and noise; residuals favor small values.
  function automatic logic [SAMPLE_W-1:0] pick_sample(dir_e d);
    int r;
    int v;
    r = $urandom_range(99, 0);
    if (d == DIR_ENCODE) begin
      if (r < 10) begin
        v = $urandom_range(1023, 0);
      end else if (r < 30) begin
        v = $urandom_range(1, 0) ? 255 : 0;
      end else if (r < 65) begin
        v = smooth_px + $urandom_range(8, 0) - 4;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        smooth_px = v;
      end else begin
        v = $urandom_range(255, 0);
      end
    end else begin
      if (r < 25) begin
        v = $urandom_range(1023, 0);
      end else if (r < 40) begin
        case ($urandom_range(3, 0))
          0:       v = -512;
          1:       v = 511;
          2:       v = 0;
          default: v = -1;
        endcase
      end else begin
        v = $urandom_range(32, 0) - 16;
      end
    end
    return v[SAMPLE_W-1:0];
  endfunction

  // Offer one pixel transaction after a random gap and note it once accepted
  task automatic send_item(logic [SAMPLE_W-1:0] smp, logic soi);
    int gap;
    gap = $urandom_range(tx_max_wait, 0);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, smp};
    s_axis_tuser  <= soi;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(smp, soi);
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic finish_stream();
    s_axis_tvalid <= 1'b0;
    streaming = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  // Write all four registers on consecutive cycles while the core is idle
  task automatic write_config(pred_mode_e m, shift_t s, width_t w, dir_e d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PRED_MODE;
    cfg_data_i <= CFG_W'(m);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_QUANT_SHIFT;
    cfg_data_i <= CFG_W'(s);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_IMAGE_WIDTH;
    cfg_data_i <= CFG_W'(w);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_DIRECTION;
    cfg_data_i <= CFG_W'(d);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_config(m, s, w, d);
  endtask

  initial begin
    int         phase;
    int         n_items;
    int         r;
    int         prev_w;
    int         rand_items;
    bit         soi;
    pred_mode_e m;
    shift_t     s;
    width_t     w;
    dir_e       d;

    sb = new();
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_PRED_MODE;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    m_axis_tready <= 1'b0;
    repeat (RESET_CYC) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings, no start marker: pixel extremes and out-of-range samples
    streaming = 1'b1;
    send_item(10'd0, 1'b0);
    send_item(10'd255, 1'b0);
    send_item(10'h200, 1'b0);
    send_item(10'h1FF, 1'b0);
    send_item(10'h100, 1'b0);
    finish_stream();

    // Width zero behaves as one pixel per row; coarsest quantization
    write_config(PRED_ABOVE, 3'd7, 13'd0, DIR_ENCODE);
    streaming = 1'b1;
    send_item(10'd255, 1'b1);
    send_item(10'd0, 1'b0);
    send_item(10'd128, 1'b0);
    send_item(10'd127, 1'b0);
    finish_stream();

    // Decode with residual extremes
    write_config(PRED_AVG, 3'd0, 13'd2, DIR_DECODE);
    streaming = 1'b1;
    send_item(10'h200, 1'b1);
    send_item(10'h1FF, 1'b0);
    send_item(10'h000, 1'b0);
    send_item(10'h3FF, 1'b0);
    finish_stream();

    // Lower the width in the middle of a row, then keep going without a marker
    write_config(PRED_PLANE, 3'd3, 13'd4, DIR_ENCODE);
    streaming = 1'b1;
    send_item(10'd10, 1'b1);
    send_item(10'd200, 1'b0);
    send_item(10'd3, 1'b0);
    send_item(10'd255, 1'b0);
    send_item(10'd0, 1'b0);
    send_item(10'd77, 1'b0);
    finish_stream();
    write_config(PRED_PLANE, 3'd3, 13'd2, DIR_ENCODE);
    streaming = 1'b1;
    send_item(10'd90, 1'b0);
    send_item(10'd91, 1'b0);
    send_item(10'd250, 1'b0);
    finish_stream();
    prev_w = 2;

    // Random phases; widths only grow at a start-of-image marker
    phase      = 0;
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      m = (phase < 8) ? pred_mode_e'(phase) : pred_mode_e'($urandom_range(7, 0));
      if (phase == 0) s = 3'd0;
      else if (phase == 1) s = 3'd7;
      else s = shift_t'($urandom_range(7, 0));
      d = (phase < 8) ? dir_e'(phase[0]) : dir_e'($urandom_range(1, 0));
      r = $urandom_range(99, 0);
      if (r < 3) w = 13'd0;
      else if (r < 60) w = width_t'($urandom_range(12, 1));
      else if (r < 85) w = width_t'($urandom_range(64, 13));
      else if (r < 93) w = 13'd4096;
      else w = width_t'($urandom_range(8191, 4097));
      n_items = $urandom_range(60, 8);
      tx_max_wait = ($urandom_range(3, 0) == 0) ? 0 : 12;
      rx_max_wait = ($urandom_range(3, 0) == 0) ? 0 : 12;
      // Send at full rate while the receiver holds off, so the core fills up
      if (phase == 10) begin
        n_items     = 60;
        tx_max_wait = 0;
        hold_req    = 1'b1;
      end
      soi = !(eff_width(w) <= prev_w && $urandom_range(2, 0) == 0);
      write_config(m, s, w, d);
      streaming = 1'b1;
      for (int i = 0; i < n_items; i++) begin
        send_item(pick_sample(d), (i == 0) ? soi : ($urandom_range(49, 0) == 0));
      end
      finish_stream();
      prev_w     = eff_width(w);
      rand_items = rand_items + n_items;
      phase++;
    end

    $display("covered %0d pixel transactions over %0d random phases plus directed cases,",
             sb.n_noted, phase);
    $display("all predictors, both directions, shifts 0..7, widths 0..8191; %0d results checked",
             sb.n_checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ljpc_pkg.sv
rtl/ljpc_front.sv
rtl/ljpc_queue.sv
rtl/ljpc_back.sv
rtl/lossless_jpeg_predictive_codec_core.sv
sim/lossless_jpeg_predictive_codec_core_test.sv
